FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define AST_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define AST_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/mmix_pkg.sv
// Package: types, constants and codes of the motor mixer.
package mmix_pkg;

    localparam int MOTOR_COUNT = 16;
    localparam int IDX_W       = 4;
    localparam int MOTOR_SCALE = 10000;
    localparam int LIM_CAP     = MOTOR_SCALE / 4;
    localparam int DVD_W       = 30;
    localparam int DIV_STEPS   = DVD_W;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [4:0]       cnt_t;

    localparam idx_t IDX_LAST = idx_t'(MOTOR_COUNT - 1);

    // full scale of S*vf: MOTOR_SCALE * 25600 * 16384
    localparam longint MIX_FULL = longint'(MOTOR_SCALE) * 64'sd25600 * 64'sd16384;
    // reciprocal of 100 in Q32, rounded up
    localparam logic [25:0] RECIP100 = 26'(((64'd1 << 32) + 64'd99) / 64'd100);
    // reciprocal of MOTOR_SCALE in Q44, rounded up
    localparam logic [30:0] RECIP_SCALE =
        31'(((64'd1 << 44) + 64'(MOTOR_SCALE) - 64'd1) / 64'(MOTOR_SCALE));

    localparam logic [2:0] CFG_PWM_MIN   = 3'd0;
    localparam logic [2:0] CFG_PWM_MAX   = 3'd1;
    localparam logic [2:0] CFG_PWM_START = 3'd2;
    localparam logic [2:0] CFG_NOMINAL   = 3'd3;
    localparam logic [2:0] CFG_LIM_STEP  = 3'd4;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_VF, S_SCAN, S_MAC, S_MIX, S_SCALE,
        S_VAL, S_NUM, S_PDIV, S_EMIT, S_DECAY
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_START, CMD_DIV, CMD_VF, CMD_SCAN, CMD_MAC,
        CMD_MIX, CMD_SCALE, CMD_VAL, CMD_NUM, CMD_PDIV, CMD_EMIT, CMD_DECAY
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t    op;
        logic [1:0] term;
    } ctrl_cmd_t;

    typedef struct packed {
        logic active;
        logic idx_end;
    } dp_status_t;

endpackage

FILE: sv/mmix_ctrl.sv
// Controller: sequences the divider, the per-motor pass and the limiter decay.
module mmix_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   op,
    input  mmix_pkg::dp_status_t   status,
    output mmix_pkg::ctrl_cmd_t    cmd,
    output logic                   busy
);

    mmix_pkg::state_t state_reg, state_next;
    mmix_pkg::cnt_t   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmix_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        cmd.op     = mmix_pkg::CMD_NONE;
        cmd.term   = cnt_reg[1:0];
        busy       = (state_reg != mmix_pkg::S_IDLE);
        case (state_reg)
            mmix_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (op == mmix_pkg::OP_COMMAND)
                    begin
                        cmd.op     = mmix_pkg::CMD_START;
                        state_next = mmix_pkg::S_DIV;
                    end
                    else
                    begin
                        cmd.op = mmix_pkg::CMD_LOAD;
                    end
                end
            end
            mmix_pkg::S_DIV:
            begin
                cmd.op = mmix_pkg::CMD_DIV;
                if (cnt_reg == mmix_pkg::cnt_t'(mmix_pkg::DIV_STEPS - 1))
                    state_next = mmix_pkg::S_VF;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            mmix_pkg::S_VF:
            begin
                cmd.op     = mmix_pkg::CMD_VF;
                state_next = mmix_pkg::S_SCAN;
            end
            mmix_pkg::S_SCAN:
            begin
                cmd.op = mmix_pkg::CMD_SCAN;
                if (status.active)
                    state_next = mmix_pkg::S_MAC;
                else if (status.idx_end)
                    state_next = mmix_pkg::S_DECAY;
            end
            mmix_pkg::S_MAC:
            begin
                cmd.op = mmix_pkg::CMD_MAC;
                if (cnt_reg[1:0] == 2'd3)
                    state_next = mmix_pkg::S_MIX;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            mmix_pkg::S_MIX:
            begin
                cmd.op     = mmix_pkg::CMD_MIX;
                state_next = mmix_pkg::S_SCALE;
            end
            mmix_pkg::S_SCALE:
            begin
                cmd.op     = mmix_pkg::CMD_SCALE;
                state_next = mmix_pkg::S_VAL;
            end
            mmix_pkg::S_VAL:
            begin
                cmd.op     = mmix_pkg::CMD_VAL;
                state_next = mmix_pkg::S_NUM;
            end
            mmix_pkg::S_NUM:
            begin
                cmd.op     = mmix_pkg::CMD_NUM;
                state_next = mmix_pkg::S_PDIV;
            end
            mmix_pkg::S_PDIV:
            begin
                cmd.op     = mmix_pkg::CMD_PDIV;
                state_next = mmix_pkg::S_EMIT;
            end
            mmix_pkg::S_EMIT:
            begin
                cmd.op     = mmix_pkg::CMD_EMIT;
                state_next = status.idx_end ? mmix_pkg::S_DECAY : mmix_pkg::S_SCAN;
            end
            mmix_pkg::S_DECAY:
            begin
                cmd.op     = mmix_pkg::CMD_DECAY;
                state_next = mmix_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mmix_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mmix_dp.sv
// Datapath: config, mix table, divider, MAC, scaling, PWM mapping, limiter.
module mmix_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mmix_pkg::ctrl_cmd_t   cmd,
    output mmix_pkg::dp_status_t  status,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [3:0]            motor_index,
    input  logic signed [15:0]    coef_throttle,
    input  logic signed [15:0]    coef_pitch,
    input  logic signed [15:0]    coef_roll,
    input  logic signed [15:0]    coef_yaw,
    input  logic [13:0]           throttle_cmd,
    input  logic signed [14:0]    pitch_cmd,
    input  logic signed [14:0]    roll_cmd,
    input  logic signed [14:0]    yaw_cmd,
    input  logic [15:0]           battery_mv,
    input  logic                  armed,
    output logic                  strobe,
    output logic [3:0]            out_motor,
    output logic [13:0]           motor_value,
    output logic [15:0]           pwm_compare,
    output logic                  last
);

    // configuration
    logic [15:0] pwm_min_reg, pwm_max_reg, pwm_start_reg, nominal_reg;
    logic [11:0] lim_step_reg;

    // mix table and active flags
    logic [63:0]                        mix_mem [mmix_pkg::MOTOR_COUNT];
    logic [mmix_pkg::MOTOR_COUNT-1:0]   active_reg;
    logic [15:0]                        limiter_reg;

    // per-command operands
    logic [13:0]        thr_reg;
    logic signed [14:0] pit_reg, rol_reg, yaw_reg;
    logic               armed_reg;
    logic [29:0]        minsc_reg;
    logic [mmix_pkg::DVD_W-1:0] dvd_reg;
    logic [15:0]        rem_reg;
    logic signed [15:0] vf_reg;
    mmix_pkg::idx_t     idx_reg;

    // per-motor pipeline
    logic signed [33:0] acc_reg;
    logic signed [49:0] mixed_reg;
    logic [45:0]        r100_reg;
    logic               sat_reg, pos_reg;
    logic [13:0]        val_reg;
    logic signed [32:0] num_reg;
    logic [61:0]        pq_reg;
    logic               neg_reg;

    // output registers
    logic        strobe_reg;
    logic [3:0]  out_motor_reg;
    logic [13:0] value_reg;
    logic [15:0] pwm_reg;
    logic        last_reg;

    // combinational helpers
    logic signed [17:0] thr_diff;
    logic [13:0]        thr_clamped;
    logic [15:0]        nom_eff;
    logic [16:0]        rem_sh;
    logic               div_bit;
    logic [63:0]        entry;
    logic signed [15:0] mac_a, mac_b;
    logic signed [31:0] mac_prod;
    logic signed [49:0] mix_prod;
    logic               is_sat, is_pos;
    logic [16:0]        lim_sum;
    logic signed [16:0] lim_dec;
    logic signed [16:0] pwm_span;
    logic signed [32:0] num_calc;
    logic [17:0]        pw_q;
    logic [15:0]        pwm_sel;
    logic               later_active;
    logic signed [15:0] vf_calc;

    assign entry   = mix_mem[idx_reg];
    assign nom_eff = (nominal_reg == 16'd0) ? 16'd1 : nominal_reg;

    always_comb
    begin
        thr_diff = $signed({4'b0, throttle_cmd}) - $signed({2'b0, limiter_reg});
        if (thr_diff < 0)
            thr_clamped = '0;
        else if (thr_diff > 18'sd10000)
            thr_clamped = 14'(mmix_pkg::MOTOR_SCALE);
        else
            thr_clamped = thr_diff[13:0];
    end

    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[mmix_pkg::DVD_W-1]};
        div_bit = (rem_sh >= {1'b0, nom_eff});
    end

    always_comb
    begin
        if (dvd_reg == '0)
            vf_calc = 16'sh7FFF;
        else if (dvd_reg > 30'd65536)
            vf_calc = 16'sh8000;
        else
            vf_calc = $signed(16'(17'h08000 - dvd_reg[16:0]));
    end

    always_comb
    begin
        case (cmd.term)
            2'd0:
            begin
                mac_a = $signed({2'b0, thr_reg});
                mac_b = $signed(entry[15:0]);
            end
            2'd1:
            begin
                mac_a = 16'(pit_reg);
                mac_b = $signed(entry[31:16]);
            end
            2'd2:
            begin
                mac_a = 16'(rol_reg);
                mac_b = $signed(entry[47:32]);
            end
            default:
            begin
                mac_a = 16'(yaw_reg);
                mac_b = $signed(entry[63:48]);
            end
        endcase
        mac_prod = mac_a * mac_b;
    end

    assign mix_prod = acc_reg * vf_reg;
    assign is_sat   = (mixed_reg >= 50'(mmix_pkg::MIX_FULL));
    assign is_pos   = (mixed_reg > 50'sd0);
    assign lim_sum  = {1'b0, limiter_reg} + {5'b0, lim_step_reg};
    assign lim_dec  = $signed({1'b0, limiter_reg}) - $signed({5'b0, lim_step_reg});
    assign pwm_span = $signed({1'b0, pwm_max_reg}) - $signed({1'b0, pwm_min_reg});
    assign num_calc = $signed({1'b0, val_reg}) * pwm_span + $signed({3'b0, minsc_reg});
    assign pw_q     = pq_reg[61:44];

    always_comb
    begin
        if (!armed_reg)
            pwm_sel = '0;
        else if (neg_reg || (pw_q < {2'b0, pwm_start_reg}))
            pwm_sel = pwm_start_reg;
        else if (pw_q > {2'b0, pwm_max_reg})
            pwm_sel = pwm_max_reg;
        else
            pwm_sel = pw_q[15:0];
    end

    always_comb
    begin
        later_active = 1'b0;
        for (int i = 0; i < mmix_pkg::MOTOR_COUNT; i++)
        begin
            if ((mmix_pkg::idx_t'(i) > idx_reg) && active_reg[i])
                later_active = 1'b1;
        end
    end

    assign status.active  = active_reg[idx_reg];
    assign status.idx_end = (idx_reg == mmix_pkg::IDX_LAST);

    // control state: config, active flags, limiter, output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_min_reg   <= 16'd1000;
            pwm_max_reg   <= 16'd2000;
            pwm_start_reg <= 16'd1100;
            nominal_reg   <= 16'd12000;
            lim_step_reg  <= 12'd10;
            active_reg    <= '0;
            limiter_reg   <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mmix_pkg::CFG_PWM_MIN:   pwm_min_reg   <= cfg_data;
                    mmix_pkg::CFG_PWM_MAX:   pwm_max_reg   <= cfg_data;
                    mmix_pkg::CFG_PWM_START: pwm_start_reg <= cfg_data;
                    mmix_pkg::CFG_NOMINAL:   nominal_reg   <= cfg_data;
                    mmix_pkg::CFG_LIM_STEP:  lim_step_reg  <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (cmd.op == mmix_pkg::CMD_LOAD)
                active_reg[motor_index] <= (coef_throttle != 16'sd0) ||
                    (coef_pitch != 16'sd0) || (coef_roll != 16'sd0) ||
                    (coef_yaw != 16'sd0);
            if ((cmd.op == mmix_pkg::CMD_SCALE) && is_sat)
                limiter_reg <= lim_sum[16] ? 16'hFFFF : lim_sum[15:0];
            if (cmd.op == mmix_pkg::CMD_DECAY)
            begin
                if (lim_dec < 0)
                    limiter_reg <= '0;
                else if (lim_dec > 17'(mmix_pkg::LIM_CAP))
                    limiter_reg <= 16'(mmix_pkg::LIM_CAP);
                else
                    limiter_reg <= lim_dec[15:0];
            end
            strobe_reg <= (cmd.op == mmix_pkg::CMD_EMIT);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mmix_pkg::CMD_LOAD:
                mix_mem[motor_index] <= {coef_yaw, coef_roll, coef_pitch, coef_throttle};
            mmix_pkg::CMD_START:
            begin
                thr_reg   <= thr_clamped;
                pit_reg   <= pitch_cmd;
                rol_reg   <= roll_cmd;
                yaw_reg   <= yaw_cmd;
                armed_reg <= armed;
                minsc_reg <= {14'b0, pwm_min_reg} * 30'(mmix_pkg::MOTOR_SCALE);
                dvd_reg   <= {battery_mv, 14'b0};
                rem_reg   <= '0;
                idx_reg   <= '0;
            end
            mmix_pkg::CMD_DIV:
            begin
                rem_reg <= div_bit ? 16'(rem_sh - {1'b0, nom_eff}) : rem_sh[15:0];
                dvd_reg <= {dvd_reg[mmix_pkg::DVD_W-2:0], div_bit};
            end
            mmix_pkg::CMD_VF:
                vf_reg <= vf_calc;
            mmix_pkg::CMD_SCAN:
            begin
                acc_reg <= '0;
                if (!active_reg[idx_reg])
                    idx_reg <= idx_reg + 1'b1;
            end
            mmix_pkg::CMD_MAC:
                acc_reg <= acc_reg + 34'(mac_prod);
            mmix_pkg::CMD_MIX:
                mixed_reg <= mix_prod;
            mmix_pkg::CMD_SCALE:
            begin
                sat_reg  <= is_sat;
                pos_reg  <= is_pos;
                r100_reg <= mixed_reg[41:22] * 46'(mmix_pkg::RECIP100);
            end
            mmix_pkg::CMD_VAL:
            begin
                if (sat_reg)
                    val_reg <= 14'(mmix_pkg::MOTOR_SCALE);
                else if (pos_reg)
                    val_reg <= r100_reg[45:32];
                else
                    val_reg <= '0;
            end
            mmix_pkg::CMD_NUM:
                num_reg <= num_calc;
            mmix_pkg::CMD_PDIV:
            begin
                neg_reg <= num_reg[32];
                pq_reg  <= num_reg[30:0] * 62'(mmix_pkg::RECIP_SCALE);
            end
            mmix_pkg::CMD_EMIT:
            begin
                out_motor_reg <= idx_reg;
                value_reg     <= val_reg;
                pwm_reg       <= pwm_sel;
                last_reg      <= !later_active;
                idx_reg       <= idx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign strobe      = strobe_reg;
    assign out_motor   = out_motor_reg;
    assign motor_value = value_reg;
    assign pwm_compare = pwm_reg;
    assign last        = strobe_reg & last_reg;

endmodule

FILE: sv/multirotor_motor_mixer.sv
// Top level: multirotor motor mixer with throttle limiter.
// Usage:
//   Items enter on start while busy is low. op = 0 is a coefficient load:
//   it writes one motor's four mix weights as it is accepted, busy stays
//   low and no result follows. op = 1 is a control command: busy rises
//   and the block emits one result per active motor, lowest index first,
//   each on strobe for exactly one cycle with out_motor, motor_value,
//   pwm_compare and last (high on the final result of the command).
//   The receiver cannot stall; it must take every strobe.
// Steps of a command:
//   a start step, the restoring voltage divider (one quotient bit per
//   cycle), the voltage factor, then the motor scan: a scan step for
//   each inactive motor, and for each active one a scan step, 4
//   multiply-accumulate steps, voltage multiply, 1/100 scaling, PWM map
//   and reciprocal divide, emit; and a limiter decay step at the end.
// Reset:
//   rst_n clears every motor to inactive, the limiter to zero and the
//   registers to their defaults. Configuration writes (cfg_write,
//   cfg_index, cfg_data) take effect at once and belong in idle time.
module multirotor_motor_mixer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               op,
    input  logic [3:0]         motor_index,
    input  logic signed [15:0] coef_throttle,
    input  logic signed [15:0] coef_pitch,
    input  logic signed [15:0] coef_roll,
    input  logic signed [15:0] coef_yaw,
    input  logic [13:0]        throttle_cmd,
    input  logic signed [14:0] pitch_cmd,
    input  logic signed [14:0] roll_cmd,
    input  logic signed [14:0] yaw_cmd,
    input  logic [15:0]        battery_mv,
    input  logic               armed,
    output logic               strobe,
    output logic [3:0]         out_motor,
    output logic [13:0]        motor_value,
    output logic [15:0]        pwm_compare,
    output logic               last
);

`include "assert_macros.svh"

    mmix_pkg::ctrl_cmd_t  cmd;
    mmix_pkg::dp_status_t status;

    // sequencer
    mmix_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // arithmetic, table and output registers
    mmix_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .motor_index   (motor_index),
        .coef_throttle (coef_throttle),
        .coef_pitch    (coef_pitch),
        .coef_roll     (coef_roll),
        .coef_yaw      (coef_yaw),
        .throttle_cmd  (throttle_cmd),
        .pitch_cmd     (pitch_cmd),
        .roll_cmd      (roll_cmd),
        .yaw_cmd       (yaw_cmd),
        .battery_mv    (battery_mv),
        .armed         (armed),
        .strobe        (strobe),
        .out_motor     (out_motor),
        .motor_value   (motor_value),
        .pwm_compare   (pwm_compare),
        .last          (last)
    );

    // results only appear while a command is in progress
    `AST_IMPL(a_strobe_in_cmd, strobe, busy)
    // an accepted command occupies the block
    `AST_NEXT(a_cmd_busy, start && !busy && op, busy)
    // a load finishes in its accept cycle
    `AST_NEXT(a_load_idle, start && !busy && !op, !busy)
    // last only marks a delivered result
    `AST_IMPL(a_last_strobe, last, strobe)

endmodule

FILE: tb/sv/multirotor_motor_mixer_tb.sv
// Testbench of the motor mixer: directed and random items checked against a built-in predictor.
`timescale 1ns / 100ps

module multirotor_motor_mixer_tb;

    localparam int     NUM_MOTORS  = 16;
    localparam longint SCALE       = 10000;
    localparam longint FULL_MIX    = SCALE * 64'sd25600 * 64'sd16384;
    localparam longint CAP_LIMIT   = SCALE / 4;
    localparam int     SETTLE_CYC  = 230;   // covers the longest command, sixteen active motors
    localparam int     STALL_LIMIT = 4000;

    typedef struct {
        logic               op;
        logic [3:0]         idx;
        logic signed [15:0] c_thr, c_pit, c_rol, c_yaw;
        logic [13:0]        thr;
        logic signed [14:0] pit, rol, yaw;
        logic [15:0]        batt;
        logic               arm;
    } item_t;

    typedef struct {
        logic [3:0]  motor;
        logic [13:0] value;
        logic [15:0] pwm;
        logic        fin;
    } motor_out_t;

    logic               clk, rst_n, start, busy, cfg_write;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               op, armed, strobe, last;
    logic [3:0]         motor_index, out_motor;
    logic signed [15:0] coef_throttle, coef_pitch, coef_roll, coef_yaw;
    logic [13:0]        throttle_cmd, motor_value;
    logic signed [14:0] pitch_cmd, roll_cmd, yaw_cmd;
    logic [15:0]        battery_mv, pwm_compare;

    // predictor state
    logic signed [15:0] mix_coef [NUM_MOTORS][4];
    longint             thr_limit;
    longint             p_min, p_max, p_start, p_nom, p_step;

    motor_out_t motor_results[$];
    int         err_count;
    int         quiet_cycles;
    int         burst_left;
    bit         gaps_on;

    multirotor_motor_mixer u_top (
        .clk, .rst_n, .start, .busy, .cfg_write, .cfg_index, .cfg_data,
        .op, .motor_index, .coef_throttle, .coef_pitch, .coef_roll, .coef_yaw,
        .throttle_cmd, .pitch_cmd, .roll_cmd, .yaw_cmd, .battery_mv, .armed,
        .strobe, .out_motor, .motor_value, .pwm_compare, .last
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Works out the results of one command and advances the limiter.
    function automatic void mix_command(item_t it);
        longint thr, q, vf, nom, lim, s, mixed, val, pw, num;
        motor_out_t r;
        int produced;
        produced = 0;
        thr = longint'(it.thr) - thr_limit;
        if (thr < 0) thr = 0;
        if (thr > SCALE) thr = SCALE;
        nom = (p_nom == 0) ? 1 : p_nom;
        q = (longint'(it.batt) << 14) / nom;
        vf = 32768 - q;
        if (vf < -32768) vf = -32768;
        if (vf > 32767) vf = 32767;
        lim = thr_limit;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            if (mix_coef[m][0] == 0 && mix_coef[m][1] == 0 &&
                mix_coef[m][2] == 0 && mix_coef[m][3] == 0)
                continue;
            s = thr * longint'(mix_coef[m][0]) + longint'(it.pit) * longint'(mix_coef[m][1])
                + longint'(it.rol) * longint'(mix_coef[m][2])
                + longint'(it.yaw) * longint'(mix_coef[m][3]);
            mixed = s * vf;
            if (mixed >= FULL_MIX)
            begin
                lim += p_step;
                if (lim > 65535) lim = 65535;
                val = SCALE;
            end
            else if (mixed <= 0)
                val = 0;
            else
                val = mixed / (FULL_MIX / SCALE);
            if (it.arm)
            begin
                num = val * (p_max - p_min) + p_min * SCALE;
                if (num < 0)
                    pw = p_start;
                else
                begin
                    pw = num / SCALE;
                    if (pw < p_start) pw = p_start;
                    else if (pw > p_max) pw = p_max;
                end
            end
            else
                pw = 0;
            r.motor = 4'(m);
            r.value = 14'(val);
            r.pwm   = 16'(pw);
            r.fin   = 1'b0;
            motor_results.push_back(r);
            produced++;
        end
        if (produced > 0)
            motor_results[$].fin = 1'b1;
        lim -= p_step;
        if (lim < 0) lim = 0;
        if (lim > CAP_LIMIT) lim = CAP_LIMIT;
        thr_limit = lim;
    endfunction

    // Drives one item and holds start until the block takes it.
    task automatic issue_item(item_t it);
        start         <= 1'b1;
        op            <= it.op;
        motor_index   <= it.idx;
        coef_throttle <= it.c_thr;
        coef_pitch    <= it.c_pit;
        coef_roll     <= it.c_rol;
        coef_yaw      <= it.c_yaw;
        throttle_cmd  <= it.thr;
        pitch_cmd     <= it.pit;
        roll_cmd      <= it.rol;
        yaw_cmd       <= it.yaw;
        battery_mv    <= it.batt;
        armed         <= it.arm;
        do
            @(posedge clk);
        while (busy);
        if (it.op == mmix_pkg::OP_LOAD)
        begin
            mix_coef[it.idx][0] = it.c_thr;
            mix_coef[it.idx][1] = it.c_pit;
            mix_coef[it.idx][2] = it.c_rol;
            mix_coef[it.idx][3] = it.c_yaw;
        end
        else
            mix_command(it);
        // bursts of items, random gaps between them when gaps_on is set
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 7);
            if (gaps_on)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (motor_results.size() != 0) @(posedge clk);
        // a command with no active motor leaves nothing to wait on
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (index)
            mmix_pkg::CFG_PWM_MIN:   p_min   = data;
            mmix_pkg::CFG_PWM_MAX:   p_max   = data;
            mmix_pkg::CFG_PWM_START: p_start = data;
            mmix_pkg::CFG_NOMINAL:   p_nom   = data;
            mmix_pkg::CFG_LIM_STEP:  p_step  = data[11:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int mn, int mx, int st, int nom, int stp);
        wait_idle();
        write_reg(mmix_pkg::CFG_PWM_MIN, 16'(mn));
        write_reg(mmix_pkg::CFG_PWM_MAX, 16'(mx));
        write_reg(mmix_pkg::CFG_PWM_START, 16'(st));
        write_reg(mmix_pkg::CFG_NOMINAL, 16'(nom));
        write_reg(mmix_pkg::CFG_LIM_STEP, 16'(stp));
    endtask

    function automatic item_t load_item(int m, int ct, int cp, int cr, int cy);
        item_t it;
        it = '{default: '0};
        it.op = mmix_pkg::OP_LOAD;
        it.idx = 4'(m);
        it.c_thr = 16'(ct);
        it.c_pit = 16'(cp);
        it.c_rol = 16'(cr);
        it.c_yaw = 16'(cy);
        return it;
    endfunction

    function automatic item_t cmd_item(int t, int p, int r, int y, int b, bit a);
        item_t it;
        it = '{default: '0};
        it.op = mmix_pkg::OP_COMMAND;
        it.thr = 14'(t);
        it.pit = 15'(p);
        it.rol = 15'(r);
        it.yaw = 15'(y);
        it.batt = 16'(b);
        it.arm = a;
        return it;
    endfunction

    function automatic int rand_coef();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 51200) - 25600;   // within +-100 percent
            default: return $signed(16'($urandom));
        endcase
    endfunction

    function automatic int rand_cmd();
        if ($urandom_range(0, 2) == 0)
            return $signed(15'($urandom));
        return $urandom_range(0, 6000) - 3000;
    endfunction

    // Mostly commands on a mostly populated table, with loads mixed in.
    function automatic item_t rand_item();
        item_t it;
        if ($urandom_range(0, 9) < 4)
            return load_item($urandom_range(0, 15), rand_coef(), rand_coef(),
                             rand_coef(), rand_coef());
        it = cmd_item($urandom_range(0, 1) ? $urandom_range(0, 16383) : $urandom_range(0, 10000),
                      rand_cmd(), rand_cmd(), rand_cmd(),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                : $urandom_range(9000, 17000),
                      $urandom_range(0, 5) != 0);
        return it;
    endfunction

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            issue_item(rand_item());
    endtask

    // Extremes of every field, empty table, disarmed and saturation.
    task automatic test_directed();
        issue_item(cmd_item(5000, 0, 0, 0, 12000, 1));              // no active motor
        issue_item(load_item(0, 25600, 25600, -25600, 25600));
        issue_item(load_item(15, -32768, -32768, -32768, -32768));
        issue_item(load_item(7, 32767, 32767, 32767, 32767));
        issue_item(cmd_item(0, 0, 0, 0, 12000, 1));
        issue_item(cmd_item(16383, 16383, 16383, 16383, 0, 1));
        issue_item(cmd_item(16383, -16384, -16384, -16384, 65535, 1));
        issue_item(cmd_item(4000, 1000, -1000, 500, 12000, 0));     // disarmed
        issue_item(cmd_item(6000, -500, 700, -300, 11000, 1));
        issue_item(load_item(7, 0, 0, 0, 0));                      // deactivates motor 7
        issue_item(cmd_item(8000, 200, 200, 200, 12000, 1));
    endtask

    // Large step with every motor saturating drives the limiter to its ceiling.
    task automatic test_limiter_ceiling();
        set_regs(1000, 2000, 1100, 12000, 4095);
        for (int m = 0; m < NUM_MOTORS; m++)
            issue_item(load_item(m, 32767, 0, 0, 0));
        issue_item(cmd_item(16383, 0, 0, 0, 0, 1));
        issue_item(cmd_item(16383, 0, 0, 0, 0, 1));
        issue_item(cmd_item(3000, 0, 0, 0, 12000, 1));
    endtask

    task automatic test_phases();
        gaps_on = 1'b1;
        set_regs(0, 65535, 0, 65535, 0);
        test_random(90);
        gaps_on = 1'b0;                                 // back to back
        set_regs(65535, 0, 65535, 0, 4095);             // zero nominal, start above max
        test_random(90);
        gaps_on = 1'b1;
        set_regs(1000, 1500, 1800, 12000, 100);
        test_random(90);
        set_regs(2000, 1000, 500, 16800, 1);
        test_random(90);
        set_regs(1000, 2000, 1100, 12000, 10);
        test_random(90);
    endtask

    // Result checker: every strobe pops the oldest expected motor result.
    always @(posedge clk)
    begin
        motor_out_t w;
        if (rst_n && strobe)
        begin
            if (motor_results.size() == 0)
                report_mismatch("unexpected result, motor", out_motor, -1);
            else
            begin
                w = motor_results.pop_front();
                if (out_motor !== w.motor)   report_mismatch("out_motor", out_motor, w.motor);
                if (motor_value !== w.value) report_mismatch("motor_value", motor_value, w.value);
                if (pwm_compare !== w.pwm)   report_mismatch("pwm_compare", pwm_compare, w.pwm);
                if (last !== w.fin)          report_mismatch("last", last, w.fin);
            end
        end
    end

    // Watchdog: cycles with neither an accepted item nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        op = 1'b0;
        motor_index = '0;
        coef_throttle = '0;
        coef_pitch = '0;
        coef_roll = '0;
        coef_yaw = '0;
        throttle_cmd = '0;
        pitch_cmd = '0;
        roll_cmd = '0;
        yaw_cmd = '0;
        battery_mv = '0;
        armed = 1'b0;
        err_count = 0;
        quiet_cycles = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        for (int m = 0; m < NUM_MOTORS; m++)
            for (int k = 0; k < 4; k++)
                mix_coef[m][k] = '0;
        thr_limit = 0;
        p_min = 1000;
        p_max = 2000;
        p_start = 1100;
        p_nom = 12000;
        p_step = 10;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limiter_ceiling();
        test_phases();

        wait_idle();
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/mmix_pkg.sv
sv/mmix_ctrl.sv
sv/mmix_dp.sv
sv/multirotor_motor_mixer.sv
tb/sv/multirotor_motor_mixer_tb.sv
